// ----- rtl/dbf_pkg.sv -----
`timescale 1ns / 1ps

package dbf_pkg;

  localparam int DEPTH_DEFAULT     = 16;
  localparam int DATA_BITS_DEFAULT = 8;

  typedef logic [1:0] kind_t;
  typedef logic [7:0] byte_t;

  localparam kind_t KIND_CPU_READ  = 2'd0;
  localparam kind_t KIND_CPU_WRITE = 2'd1;
  localparam kind_t KIND_BUS_REQ   = 2'd2;

  localparam byte_t ADDR_MODE      = 8'h82;
  localparam byte_t ADDR_FIFO      = 8'hAC;
  localparam byte_t ADDR_DIRECT_LO = 8'hC0;
  localparam byte_t ADDR_DIRECT_HI = 8'hCF;

  localparam byte_t XFER_IN  = 8'h80;
  localparam byte_t XFER_OUT = 8'h90;

  localparam int DIRECT_SPAN = 16;

endpackage

// ----- rtl/dma_byte_fifo_with_local_port_top.sv -----
`timescale 1ns / 1ps

// Channel  Handshake            Payload
// in       in_valid / in_stall  mode, reg_addr, write_data, bus_data_in
// out      out_valid / out_stall read_data, bus_data_out, bus_out_valid, bus_ack,
//                               mode_unsupported
//
// A beat that does not read the buffer goes straight into the result register; a beat
// that reads the buffer passes through the registered read of the buffer RAM first.
// Reset clears the pointers, the transfer mode and the per-entry valid bits, so an
// entry never written reads as zero.
// The input stalls while a buffer read is outstanding or while the result register
// holds a beat that the output side stalls.

module dma_byte_fifo_with_local_port_top #(
  parameter int BUFFER_DEPTH = dbf_pkg::DEPTH_DEFAULT,
  parameter int DATA_BITS    = dbf_pkg::DATA_BITS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  dbf_pkg::kind_t mode,
  input  dbf_pkg::byte_t reg_addr,
  input  dbf_pkg::byte_t write_data,
  input  dbf_pkg::byte_t bus_data_in,
  output logic           out_valid,
  input  logic           out_stall,
  output dbf_pkg::byte_t read_data,
  output dbf_pkg::byte_t bus_data_out,
  output logic           bus_out_valid,
  output logic           bus_ack,
  output logic           mode_unsupported
);

  import dbf_pkg::*;

  localparam int PTR_W = $clog2(BUFFER_DEPTH);

  logic [PTR_W-1:0]        rptr;
  logic [PTR_W-1:0]        rptr_next;
  logic [PTR_W-1:0]        wptr;
  logic [PTR_W-1:0]        wptr_next;
  byte_t                   tmode;
  byte_t                   tmode_next;
  logic [BUFFER_DEPTH-1:0] filled;
  logic                    rd_pend;
  logic                    rd_to_bus;
  logic                    rd_hit;

  logic                    acc;
  logic                    is_fifo;
  logic                    is_direct;
  logic [PTR_W-1:0]        dir_tab [DIRECT_SPAN];
  logic [PTR_W-1:0]        dir_idx;
  logic                    need_read;
  logic                    read_bus;
  logic                    imm_ack;
  logic                    imm_unsup;

  logic                    ram_we;
  logic [PTR_W-1:0]        ram_waddr;
  logic [DATA_BITS-1:0]    ram_wdata;
  logic                    ram_re;
  logic [PTR_W-1:0]        ram_raddr;
  logic [DATA_BITS-1:0]    ram_rdata;
  byte_t                   rd_byte;

  for (genvar g = 0; g < DIRECT_SPAN; g++) begin : g_dir
    assign dir_tab[g] = PTR_W'(g % BUFFER_DEPTH);
  end

  assign acc       = in_valid && !in_stall;
  assign in_stall  = rd_pend || (out_valid && out_stall);
  assign is_fifo   = (reg_addr == ADDR_FIFO);
  assign is_direct = reg_addr inside {[ADDR_DIRECT_LO:ADDR_DIRECT_HI]};
  assign dir_idx   = dir_tab[reg_addr[3:0]];

  always_comb begin
    rptr_next  = rptr;
    wptr_next  = wptr;
    tmode_next = tmode;
    ram_we     = 1'b0;
    ram_waddr  = wptr;
    ram_wdata  = DATA_BITS'(write_data);
    ram_raddr  = rptr;
    need_read  = 1'b0;
    read_bus   = 1'b0;
    imm_ack    = 1'b0;
    imm_unsup  = 1'b0;
    case (mode)
      KIND_CPU_READ: begin
        if (is_fifo) begin
          need_read = 1'b1;
          rptr_next = (rptr == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : PTR_W'(rptr + 1'b1);
        end else if (is_direct) begin
          need_read = 1'b1;
          ram_raddr = dir_idx;
        end
      end
      KIND_CPU_WRITE: begin
        if (reg_addr == ADDR_MODE) begin
          tmode_next = write_data;
        end else if (is_fifo) begin
          ram_we    = 1'b1;
          wptr_next = (wptr == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : PTR_W'(wptr + 1'b1);
        end else if (is_direct) begin
          ram_we    = 1'b1;
          ram_waddr = dir_idx;
        end
      end
      KIND_BUS_REQ: begin
        if (tmode == XFER_IN) begin
          ram_we    = 1'b1;
          ram_wdata = DATA_BITS'(bus_data_in);
          wptr_next = (wptr == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : PTR_W'(wptr + 1'b1);
          imm_ack   = 1'b1;
        end else if (tmode == XFER_OUT) begin
          need_read = 1'b1;
          read_bus  = 1'b1;
          rptr_next = (rptr == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : PTR_W'(rptr + 1'b1);
        end else begin
          imm_unsup = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign ram_re = acc && need_read;

  dbf_ram #(
    .WIDTH (DATA_BITS),
    .DEPTH (BUFFER_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (acc && ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_byte = rd_hit ? ram_rdata[7:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rptr      <= '0;
      wptr      <= '0;
      tmode     <= '0;
      filled    <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= ram_re;
      if (acc) begin
        rptr  <= rptr_next;
        wptr  <= wptr_next;
        tmode <= tmode_next;
        if (ram_we) begin
          filled[ram_waddr] <= 1'b1;
        end
      end
      if (acc && !need_read) begin
        out_valid <= 1'b1;
      end else if (rd_pend) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_to_bus <= read_bus;
      rd_hit    <= filled[ram_raddr];
    end
    if (acc && !need_read) begin
      read_data        <= '0;
      bus_data_out     <= '0;
      bus_out_valid    <= 1'b0;
      bus_ack          <= imm_ack;
      mode_unsupported <= imm_unsup;
    end else if (rd_pend) begin
      read_data        <= rd_to_bus ? '0 : rd_byte;
      bus_data_out     <= rd_to_bus ? rd_byte : '0;
      bus_out_valid    <= rd_to_bus;
      bus_ack          <= rd_to_bus;
      mode_unsupported <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_pend_empty: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> !out_valid)
    else $error("Result register busy while a buffer read returns.");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (rptr <= PTR_W'(BUFFER_DEPTH - 1)) && (wptr <= PTR_W'(BUFFER_DEPTH - 1)))
    else $error("Buffer pointer beyond the last entry.");

  a_unsup: assert property (@(posedge clk) disable iff (rst)
    (acc && mode == KIND_BUS_REQ && tmode != XFER_IN && tmode != XFER_OUT)
      |=> (out_valid && mode_unsupported && !bus_ack))
    else $error("Unsupported bus request not flagged.");

  a_bus_ack: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bus_out_valid) |-> (bus_ack && !mode_unsupported))
    else $error("Popped bus beat without acknowledge.");
`endif

endmodule

// ----- rtl/dbf_ram.sv -----
`timescale 1ns / 1ps

module dbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- tb/sv/dma_byte_fifo_with_local_port_top_tb.sv -----
`timescale 1ns / 1ps

module dma_byte_fifo_with_local_port_top_tb;
  import dbf_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    kind_t mode;
    byte_t reg_addr;
    byte_t write_data;
    byte_t bus_data_in;
  } port_beat_t;

  typedef struct packed {
    byte_t read_data;
    byte_t bus_data_out;
    logic  bus_out_valid;
    logic  bus_ack;
    logic  mode_unsupported;
  } port_reply_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_stall;
  kind_t mode = KIND_CPU_READ;
  byte_t reg_addr = '0;
  byte_t write_data = '0;
  byte_t bus_data_in = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  byte_t read_data;
  byte_t bus_data_out;
  logic  bus_out_valid;
  logic  bus_ack;
  logic  mode_unsupported;

  port_beat_t  beats_to_send[$];
  port_reply_t awaited_replies[$];
  port_beat_t  beat_on_port;

  byte_t      shadow_buf [DEPTH_DEFAULT];
  logic [3:0] shadow_rd = '0;
  logic [3:0] shadow_wr = '0;
  byte_t      shadow_xfer = '0;

  int errors = 0;
  int beats_sent = 0;
  int replies_seen = 0;
  int gap_left = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  int cpu_reads = 0;
  int cpu_writes = 0;
  int bus_served = 0;
  int bus_refused = 0;
  int pointer_wraps = 0;

  dma_byte_fifo_with_local_port_top dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .mode             (mode),
    .reg_addr         (reg_addr),
    .write_data       (write_data),
    .bus_data_in      (bus_data_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .read_data        (read_data),
    .bus_data_out     (bus_data_out),
    .bus_out_valid    (bus_out_valid),
    .bus_ack          (bus_ack),
    .mode_unsupported (mode_unsupported)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic byte_t rnd8();
    return byte_t'($urandom_range(0, 255));
  endfunction

  function automatic logic [3:0] bump(logic [3:0] p);
    if (p == 4'd15) begin
      pointer_wraps++;
    end
    return p + 4'd1;
  endfunction

  function automatic port_reply_t serve_beat(port_beat_t b);
    port_reply_t r;
    logic        direct;
    logic [3:0]  slot;
    r = '0;
    direct = (b.reg_addr >= ADDR_DIRECT_LO) && (b.reg_addr <= ADDR_DIRECT_HI);
    slot = 4'(b.reg_addr - ADDR_DIRECT_LO);
    case (b.mode)
      KIND_CPU_READ: begin
        cpu_reads++;
        if (b.reg_addr == ADDR_FIFO) begin
          r.read_data = shadow_buf[shadow_rd];
          shadow_rd = bump(shadow_rd);
        end else if (direct) begin
          r.read_data = shadow_buf[slot];
        end
      end
      KIND_CPU_WRITE: begin
        cpu_writes++;
        if (b.reg_addr == ADDR_MODE) begin
          shadow_xfer = b.write_data;
        end else if (b.reg_addr == ADDR_FIFO) begin
          shadow_buf[shadow_wr] = b.write_data;
          shadow_wr = bump(shadow_wr);
        end else if (direct) begin
          shadow_buf[slot] = b.write_data;
        end
      end
      KIND_BUS_REQ: begin
        if (shadow_xfer == XFER_IN) begin
          shadow_buf[shadow_wr] = b.bus_data_in;
          shadow_wr = bump(shadow_wr);
          r.bus_ack = 1'b1;
          bus_served++;
        end else if (shadow_xfer == XFER_OUT) begin
          r.bus_data_out = shadow_buf[shadow_rd];
          shadow_rd = bump(shadow_rd);
          r.bus_out_valid = 1'b1;
          r.bus_ack = 1'b1;
          bus_served++;
        end else begin
          r.mode_unsupported = 1'b1;
          bus_refused++;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic queue_beat(kind_t k, byte_t addr, byte_t wdata, byte_t bdata);
    port_beat_t b;
    b.mode = k;
    b.reg_addr = addr;
    b.write_data = wdata;
    b.bus_data_in = bdata;
    beats_to_send.push_back(b);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    port_beat_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        awaited_replies.push_back(serve_beat(beat_on_port));
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (beats_to_send.size() > 0) begin
          nxt = beats_to_send.pop_front();
          beat_on_port = nxt;
          mode <= nxt.mode;
          reg_addr <= nxt.reg_addr;
          write_data <= nxt.write_data;
          bus_data_in <= nxt.bus_data_in;
          in_valid <= 1'b1;
          beats_sent++;
          gap_left = ((beats_sent / 60) % 3 == 2) ? 0 : $urandom_range(0, 17);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    port_reply_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        replies_seen++;
        if (awaited_replies.size() == 0) begin
          errors++;
          $display("%0t: result beat with none expected, expected nothing, got %0h", $time,
                   {read_data, bus_data_out, bus_out_valid, bus_ack, mode_unsupported});
        end else begin
          want = awaited_replies.pop_front();
          check_field("read_data", want.read_data, read_data);
          check_field("bus_data_out", want.bus_data_out, bus_data_out);
          check_field("bus_out_valid", want.bus_out_valid, bus_out_valid);
          check_field("bus_ack", want.bus_ack, bus_ack);
          check_field("mode_unsupported", want.mode_unsupported, mode_unsupported);
        end
        stall_left = ((replies_seen / 50) % 3 == 1) ? 0 : $urandom_range(0, 17);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timed out after %0d cycles without a beat.", IDLE_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int n;
    logic pop_side;
    foreach (shadow_buf[i]) begin
      shadow_buf[i] = '0;
    end

    // Directed opening: empty pops, write-only and unmapped reads, bus modes and direct access.
    queue_beat(KIND_CPU_READ, ADDR_FIFO, 8'hFF, 8'hFF);
    queue_beat(KIND_CPU_READ, ADDR_MODE, 8'h00, 8'h00);
    queue_beat(KIND_CPU_READ, 8'h00, 8'h00, 8'h00);
    queue_beat(KIND_CPU_READ, 8'hFF, 8'hFF, 8'hFF);
    queue_beat(KIND_BUS_REQ, 8'h00, 8'h00, 8'hFF);
    queue_beat(KIND_CPU_WRITE, ADDR_MODE, XFER_IN, 8'h00);
    queue_beat(KIND_BUS_REQ, 8'hFF, 8'h00, 8'hFF);
    queue_beat(KIND_BUS_REQ, 8'h00, 8'hFF, 8'h00);
    queue_beat(KIND_BUS_REQ, 8'h00, 8'h00, 8'hA5);
    queue_beat(KIND_CPU_WRITE, ADDR_MODE, XFER_OUT, 8'hFF);
    queue_beat(KIND_BUS_REQ, 8'h00, 8'h00, 8'h00);
    queue_beat(KIND_BUS_REQ, 8'hFF, 8'hFF, 8'hFF);
    queue_beat(KIND_CPU_WRITE, ADDR_FIFO, 8'hFF, 8'h00);
    queue_beat(KIND_CPU_READ, ADDR_FIFO, 8'h00, 8'h00);
    queue_beat(KIND_CPU_WRITE, ADDR_DIRECT_LO, 8'h5A, 8'h00);
    queue_beat(KIND_CPU_WRITE, ADDR_DIRECT_HI, 8'hFF, 8'h00);
    queue_beat(KIND_CPU_READ, ADDR_DIRECT_LO, 8'h00, 8'h00);
    queue_beat(KIND_CPU_READ, ADDR_DIRECT_HI, 8'h00, 8'h00);
    queue_beat(KIND_CPU_READ, 8'hBF, 8'h00, 8'h00);
    queue_beat(KIND_CPU_READ, 8'hD0, 8'h00, 8'h00);
    queue_beat(KIND_CPU_WRITE, 8'h00, 8'hFF, 8'hFF);
    queue_beat(kind_t'(2'd3), 8'hFF, 8'hFF, 8'hFF);
    queue_beat(KIND_CPU_WRITE, ADDR_MODE, 8'hFF, 8'h00);
    queue_beat(KIND_BUS_REQ, 8'h00, 8'h00, 8'h77);
    queue_beat(KIND_CPU_WRITE, ADDR_MODE, 8'h00, 8'h00);

    while (beats_to_send.size() < 520) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          queue_beat(KIND_CPU_WRITE, ADDR_MODE, $urandom_range(0, 1) ? XFER_IN : XFER_OUT,
                     rnd8());
          n = $urandom_range(1, 20);
          repeat (n) queue_beat(KIND_BUS_REQ, rnd8(), rnd8(), rnd8());
        end
        3, 4: begin
          pop_side = $urandom_range(0, 1);
          n = $urandom_range(1, 20);
          repeat (n) begin
            queue_beat(pop_side ? KIND_CPU_READ : KIND_CPU_WRITE, ADDR_FIFO, rnd8(), rnd8());
          end
        end
        5, 6: begin
          n = $urandom_range(1, 6);
          repeat (n) begin
            queue_beat($urandom_range(0, 1) ? KIND_CPU_READ : KIND_CPU_WRITE,
                       ADDR_DIRECT_LO + byte_t'($urandom_range(0, 15)), rnd8(), rnd8());
          end
        end
        7: begin
          queue_beat(KIND_CPU_WRITE, ADDR_MODE, rnd8(), rnd8());
          n = $urandom_range(1, 3);
          repeat (n) queue_beat(KIND_BUS_REQ, rnd8(), rnd8(), rnd8());
        end
        8: begin
          queue_beat(kind_t'($urandom_range(0, 3)), rnd8(), rnd8(), rnd8());
        end
        default: begin
          queue_beat($urandom_range(0, 1) ? KIND_CPU_READ : KIND_CPU_WRITE,
                     $urandom_range(0, 1) ? ADDR_MODE : rnd8(), rnd8(), rnd8());
        end
      endcase
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (beats_to_send.size() != 0 || in_valid || awaited_replies.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d beats and checked %0d result beats: %0d processor reads, %0d writes.",
             beats_sent, replies_seen, cpu_reads, cpu_writes);
    $display("Bus requests served %0d, refused %0d; the pointers wrapped %0d times.",
             bus_served, bus_refused, pointer_wraps);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/dbf_pkg.sv
rtl/dbf_ram.sv
rtl/dma_byte_fifo_with_local_port_top.sv
tb/sv/dma_byte_fifo_with_local_port_top_tb.sv
